[src/bfa_pkg.sv]
// Shared types and codes for the best-fit block allocator.
// Used by bfa_table, bfa_ctrl and the top level; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package bfa_pkg;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_ALLOC = 1'b1;

  typedef struct packed {
    logic        operation;
    logic [3:0]  block_index;
    logic [15:0] request_size;
  } bfa_in_t;

  typedef struct packed {
    logic        found;
    logic [3:0]  chosen_block;
    logic [15:0] remaining_size;
  } bfa_out_t;

  typedef struct packed {
    logic rd_en;
    logic wr_en;
  } bfa_tbl_ctl_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOAD,
    S_SCAN,
    S_DRAIN,
    S_WB,
    S_DONE
  } bfa_state_t;

endpackage

`default_nettype wire

[src/bfa_table.sv]
// Free-size table: one synchronous memory with a registered read port.
// Per-entry valid bits make never-written entries read as zero after reset.
// Depends on bfa_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bfa_table
  import bfa_pkg::*;
#(
  parameter int NUM_BLOCKS = 16,
  parameter int SIZE_BITS  = 16,
  localparam int IDX_BITS  = $clog2(NUM_BLOCKS)
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire bfa_tbl_ctl_t         ctl,
  input  wire logic [IDX_BITS-1:0]  rd_addr,
  input  wire logic [IDX_BITS-1:0]  wr_addr,
  input  wire logic [SIZE_BITS-1:0] wr_data,
  output logic      [SIZE_BITS-1:0] rd_data
);

  logic [SIZE_BITS-1:0]  mem [NUM_BLOCKS];
  logic [NUM_BLOCKS-1:0] valid;
  logic [SIZE_BITS-1:0]  rd_q;
  logic                  rd_valid;

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (ctl.rd_en) begin
      rd_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid    <= '0;
      rd_valid <= 1'b0;
    end else begin
      if (ctl.wr_en) begin
        valid[wr_addr] <= 1'b1;
      end
      if (ctl.rd_en) begin
        rd_valid <= valid[rd_addr];
      end
    end
  end

  assign rd_data = rd_valid ? rd_q : '0;

endmodule

`default_nettype wire

[src/bfa_ctrl.sv]
// Sequencer for loads and best-fit searches over the free-size table,
// with the pending result and the output register. Depends on bfa_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bfa_ctrl
  import bfa_pkg::*;
#(
  parameter int NUM_BLOCKS = 16,
  parameter int SIZE_BITS  = 16,
  localparam int IDX_BITS  = $clog2(NUM_BLOCKS),
  localparam int CNT_BITS  = $clog2(NUM_BLOCKS + 1)
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic [CNT_BITS-1:0]  limit,
  input  wire logic                 req_valid,
  output logic                      req_stall,
  input  wire bfa_in_t              req,
  output logic                      rsp_valid,
  input  wire logic                 rsp_stall,
  output bfa_out_t                  rsp,
  output bfa_tbl_ctl_t              tbl,
  output logic      [IDX_BITS-1:0]  rd_addr,
  output logic      [IDX_BITS-1:0]  wr_addr,
  output logic      [SIZE_BITS-1:0] wr_data,
  input  wire logic [SIZE_BITS-1:0] rd_data
);

  bfa_state_t           state, state_next;
  bfa_in_t              item;
  logic [SIZE_BITS-1:0] req_sz;
  logic                 in_range;
  logic [CNT_BITS-1:0]  rd_cnt;
  logic                 cmp_vld;
  logic [IDX_BITS-1:0]  cmp_idx;
  logic                 hit;
  logic [IDX_BITS-1:0]  best_idx;
  logic [SIZE_BITS-1:0] best_val;
  logic [SIZE_BITS-1:0] remain;
  logic                 cmp_fit;
  logic                 accept;
  logic                 out_free;
  logic                 res_load;
  bfa_out_t             res, res_next;

  assign req_sz   = SIZE_BITS'(item.request_size);
  assign in_range = 32'(item.block_index) < 32'(NUM_BLOCKS);
  assign remain   = best_val - req_sz;
  assign accept   = req_valid && !req_stall;
  assign out_free = !rsp_valid || !rsp_stall;
  assign rd_addr  = rd_cnt[IDX_BITS-1:0];
  assign cmp_fit  = cmp_vld && (rd_data >= req_sz) && (!hit || rd_data < best_val);

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (req_valid) begin
          state_next = (req.operation == OP_ALLOC) ? S_SCAN : S_LOAD;
        end
      end
      S_LOAD:  state_next = S_DONE;
      S_SCAN: begin
        if (rd_cnt == limit) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: state_next = hit ? S_WB : S_DONE;
      S_WB:    state_next = S_DONE;
      S_DONE: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    req_stall = 1'b1;
    tbl       = '0;
    wr_addr   = best_idx;
    wr_data   = remain;
    res_load  = 1'b0;
    res_next  = '0;
    unique case (state)
      S_IDLE: req_stall = 1'b0;
      S_LOAD: begin
        tbl.wr_en               = in_range;
        wr_addr                 = IDX_BITS'(item.block_index);
        wr_data                 = req_sz;
        res_load                = 1'b1;
        res_next.found          = in_range;
        res_next.chosen_block   = item.block_index;
        res_next.remaining_size = in_range ? 16'(req_sz) : '0;
      end
      S_SCAN:  tbl.rd_en = (rd_cnt != limit);
      S_DRAIN: res_load  = !hit;
      S_WB: begin
        tbl.wr_en               = 1'b1;
        res_load                = 1'b1;
        res_next.found          = 1'b1;
        res_next.chosen_block   = 4'(best_idx);
        res_next.remaining_size = 16'(remain);
      end
      S_DONE: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cmp_vld   <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      state   <= state_next;
      cmp_vld <= tbl.rd_en;
      if (state == S_DONE && out_free) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item   <= req;
      rd_cnt <= '0;
      hit    <= 1'b0;
    end else begin
      if (tbl.rd_en) begin
        rd_cnt <= CNT_BITS'(rd_cnt + 1'b1);
      end
      // Strict less-than keeps the lowest index among equal sizes.
      if (cmp_fit) begin
        hit      <= 1'b1;
        best_idx <= cmp_idx;
        best_val <= rd_data;
      end
    end
    cmp_idx <= rd_addr;
    if (res_load) begin
      res <= res_next;
    end
    if (state == S_DONE && out_free) begin
      rsp <= res;
    end
  end

  a_scan_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) |-> (rd_cnt <= limit))
    else $error("scan counter ran past the active count");

  a_read_in_scan: assert property (@(posedge clk) disable iff (rst)
    tbl.rd_en |=> (state == S_SCAN || state == S_DRAIN))
    else $error("table read data arrived outside a search");

  a_wb_needs_hit: assert property (@(posedge clk) disable iff (rst)
    (state == S_WB) |-> hit)
    else $error("write-back without a fitting block");

  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN || state == S_WB) |-> req_stall)
    else $error("input accepted during a search");

endmodule

`default_nettype wire

[src/best_fit_block_allocator.sv]
// Best-fit block allocator: a free-size table searched by a one-entry-per-cycle
// scan. A load transaction writes one entry and posts its result before the next
// transaction can be accepted. An allocate transaction reads the active entries
// through the table's single read port, one per cycle, then decides, writes
// back the remainder and posts the result; a miss skips the write-back. The
// active entries are counted after saturation to NUM_BLOCKS. The table reads as
// all zero after reset with no clearing pass. The output register lets a
// finished result wait while the next transaction is accepted; a result that is
// still waiting when the next one is ready holds the block until it leaves.
// Register active_blocks (byte address 0) sets how many entries, from index 0,
// take part in the search; values above NUM_BLOCKS saturate.
// Depends on bfa_pkg, bfa_table and bfa_ctrl.
`timescale 1ns / 1ps
`default_nettype none

module best_fit_block_allocator
  import bfa_pkg::*;
#(
  parameter int NUM_BLOCKS = 16,
  parameter int SIZE_BITS  = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        req_valid,
  output logic             req_stall,
  input  wire bfa_in_t     req,
  output logic             rsp_valid,
  input  wire logic        rsp_stall,
  output bfa_out_t         rsp,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready
);

  localparam int IDX_BITS = $clog2(NUM_BLOCKS);
  localparam int CNT_BITS = $clog2(NUM_BLOCKS + 1);
  localparam logic [2:0] ADDR_ACTIVE  = 3'd0;
  localparam logic [4:0] ACTIVE_RESET = 5'd16;

  logic [4:0]           active_blocks;
  logic [31:0]          active_ext;
  logic [CNT_BITS-1:0]  limit;
  bfa_tbl_ctl_t         tbl;
  logic [IDX_BITS-1:0]  rd_addr;
  logic [IDX_BITS-1:0]  wr_addr;
  logic [SIZE_BITS-1:0] wr_data;
  logic [SIZE_BITS-1:0] rd_data;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      active_blocks <= ACTIVE_RESET;
    end else if (psel && penable && pwrite && pready && paddr == ADDR_ACTIVE) begin
      active_blocks <= pwdata[4:0];
    end
  end

  assign prdata = (paddr == ADDR_ACTIVE) ? {27'd0, active_blocks} : '0;

  assign active_ext = 32'(active_blocks);
  assign limit = (active_ext > 32'(NUM_BLOCKS)) ? CNT_BITS'(NUM_BLOCKS)
                                                : CNT_BITS'(active_ext);

  bfa_table #(
    .NUM_BLOCKS(NUM_BLOCKS),
    .SIZE_BITS (SIZE_BITS)
  ) u_table (
    .clk    (clk),
    .rst    (rst),
    .ctl    (tbl),
    .rd_addr(rd_addr),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_data(rd_data)
  );

  bfa_ctrl #(
    .NUM_BLOCKS(NUM_BLOCKS),
    .SIZE_BITS (SIZE_BITS)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .limit    (limit),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req      (req),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp      (rsp),
    .tbl      (tbl),
    .rd_addr  (rd_addr),
    .wr_addr  (wr_addr),
    .wr_data  (wr_data),
    .rd_data  (rd_data)
  );

endmodule

`default_nettype wire
